### hdl/pixel_replicating_scaler_defines.svh
// Assertion macros used by the scaler's top-level module.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while rst is high.
`ifndef PIXEL_REPLICATING_SCALER_DEFINES_SVH
`define PIXEL_REPLICATING_SCALER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/prs_pkg.sv
`default_nettype none

package prs_pkg;

  localparam int ADDR_W  = 32;
  localparam int PIX_W   = 16;
  localparam int MODE_W  = 3;
  localparam int SIZE_W  = 11;
  localparam int PITCH_W = 16;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;

  // Register indexes, taken from paddr[4:2].
  localparam logic [2:0] REG_SCALE_MODE   = 3'd0;
  localparam logic [2:0] REG_LINE_WIDTH   = 3'd1;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd2;
  localparam logic [2:0] REG_DEST_BASE    = 3'd3;
  localparam logic [2:0] REG_DEST_PITCH   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_COPY        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LINE_DOUBLE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRIPLE      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ONE_HALF    = 3'd4;

  localparam logic [MODE_W-1:0]  RESET_SCALE_MODE   = MODE_DOUBLE;
  localparam logic [SIZE_W-1:0]  RESET_LINE_WIDTH   = 11'd256;
  localparam logic [SIZE_W-1:0]  RESET_FRAME_HEIGHT = 11'd224;
  localparam logic [ADDR_W-1:0]  RESET_DEST_BASE    = 32'd0;
  localparam logic [PITCH_W-1:0] RESET_DEST_PITCH   = 16'd512;

  typedef struct packed {
    logic [MODE_W-1:0]  scale_mode;
    logic [SIZE_W-1:0]  line_width;
    logic [SIZE_W-1:0]  frame_height;
    logic [ADDR_W-1:0]  dest_base;
    logic [PITCH_W-1:0] dest_pitch;
  } cfg_t;

  // One source pixel's worth of writes, ready for expansion.
  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [1:0]        last_k;
    logic              two_rows;
    logic              frame_end;
  } job_t;

endpackage

`default_nettype wire

### hdl/pixel_replicating_scaler.sv
// Channel   Dir  Bits  Contents
// s_*       in   16    tdata: pixel
// m_*       out  48    tdata: write_address, pixel_out; tuser: last_copy; tlast: frame_end
// apb       in   32    registers at byte addresses 0, 4, 8, 12, 16
//
// Each source pixel occupies the output port for 1, 2, 4 or 6 writes by mode
// (none for a pixel that mode 4 drops); the single output register moves one
// write per cycle while m_tready is high, and that sets the rate. A pixel is taken in the same cycle
// the previous pixel's final write leaves, so single-write modes run at one
// pixel per cycle. rst is synchronous and restores the register defaults and
// the raster position. A stall on m_tready holds the output and backs up s_tready.
`default_nettype none

`include "pixel_replicating_scaler_defines.svh"

module pixel_replicating_scaler #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [15:0]                 s_tdata,   // [15:0] pixel
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [47:0]                 m_tdata,   // [31:0] write_address, [47:32] pixel_out
  output logic                             m_tlast,   // frame_end
  output logic                             m_tuser,   // last_copy
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [prs_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [prs_pkg::CFG_DW-1:0]  pwdata,
  output logic      [prs_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready
);

  prs_pkg::cfg_t              cfg;
  prs_pkg::job_t              job;
  logic                       base_wr, job_load, accept;
  logic [prs_pkg::ADDR_W-1:0] base_value, write_address;
  logic [prs_pkg::PIX_W-1:0]  pixel_out;

  assign accept  = s_tvalid && s_tready;
  assign m_tdata = {pixel_out, write_address};

  prs_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .base_wr    (base_wr),
    .base_value (base_value)
  );

  prs_step #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .base_wr    (base_wr),
    .base_value (base_value),
    .pixel      (s_tdata),
    .accept     (accept),
    .job        (job),
    .job_load   (job_load)
  );

  prs_expand u_expand (
    .clk           (clk),
    .rst           (rst),
    .job           (job),
    .job_load      (job_load),
    .in_ready      (s_tready),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .write_address (write_address),
    .pixel_out     (pixel_out),
    .last_copy     (m_tuser),
    .frame_end     (m_tlast)
  );

  // The frame's final write is always the final write of its pixel.
  `PRS_ASSERT_SAME(a_frame_end_on_last_copy, m_tvalid && m_tlast, m_tuser, "frame_end without last_copy")
  // More copies of the same pixel follow a transaction that is not its last.
  `PRS_ASSERT_NEXT(a_copies_follow, m_tvalid && m_tready && !m_tuser, m_tvalid, "copy sequence broken")

endmodule

`default_nettype wire

### hdl/prs_cfg.sv
`default_nettype none

module prs_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [prs_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [prs_pkg::CFG_DW-1:0]  pwdata,
  output logic      [prs_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  output prs_pkg::cfg_t                    cfg,
  output logic                             base_wr,
  output logic      [prs_pkg::ADDR_W-1:0]  base_value
);

  logic       wr;
  logic [2:0] idx;

  assign pready     = 1'b1;
  assign idx        = paddr[4:2];
  assign wr         = psel && penable && pwrite && pready;
  assign base_wr    = wr && (idx == prs_pkg::REG_DEST_BASE);
  assign base_value = pwdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_mode   <= prs_pkg::RESET_SCALE_MODE;
      cfg.line_width   <= prs_pkg::RESET_LINE_WIDTH;
      cfg.frame_height <= prs_pkg::RESET_FRAME_HEIGHT;
      cfg.dest_base    <= prs_pkg::RESET_DEST_BASE;
      cfg.dest_pitch   <= prs_pkg::RESET_DEST_PITCH;
    end else if (wr) begin
      case (idx)
        prs_pkg::REG_SCALE_MODE:   cfg.scale_mode   <= pwdata[prs_pkg::MODE_W-1:0];
        prs_pkg::REG_LINE_WIDTH:   cfg.line_width   <= pwdata[prs_pkg::SIZE_W-1:0];
        prs_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[prs_pkg::SIZE_W-1:0];
        prs_pkg::REG_DEST_BASE:    cfg.dest_base    <= pwdata[prs_pkg::ADDR_W-1:0];
        prs_pkg::REG_DEST_PITCH:   cfg.dest_pitch   <= pwdata[prs_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      prs_pkg::REG_SCALE_MODE:   prdata = prs_pkg::CFG_DW'(cfg.scale_mode);
      prs_pkg::REG_LINE_WIDTH:   prdata = prs_pkg::CFG_DW'(cfg.line_width);
      prs_pkg::REG_FRAME_HEIGHT: prdata = prs_pkg::CFG_DW'(cfg.frame_height);
      prs_pkg::REG_DEST_BASE:    prdata = prs_pkg::CFG_DW'(cfg.dest_base);
      prs_pkg::REG_DEST_PITCH:   prdata = prs_pkg::CFG_DW'(cfg.dest_pitch);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### hdl/prs_step.sv
`default_nettype none

module prs_step #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire prs_pkg::cfg_t               cfg,
  input  wire logic                        base_wr,
  input  wire logic [prs_pkg::ADDR_W-1:0]  base_value,
  input  wire logic [prs_pkg::PIX_W-1:0]   pixel,
  input  wire logic                        accept,
  output prs_pkg::job_t                    job,
  output logic                             job_load
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = (CW > RW) ? CW : RW;
  // Compare width: holds the clamped sizes, the raw register values and column + 3.
  localparam int XW = (HW + 2 > prs_pkg::SIZE_W) ? HW + 2 : prs_pkg::SIZE_W;

  logic [CW-1:0]             column;
  logic [RW-1:0]             row;
  logic [prs_pkg::ADDR_W-1:0] row_start;

  logic [XW-1:0]             lw_x, fh_x, w, h, col_x;
  logic                      line_last, frame_last_row, emit, two_rows, frame_flag;
  logic [1:0]                last_k;
  logic [prs_pkg::ADDR_W-1:0] col32, half32, offset, pitch32, a0, row_step;

  always_comb begin
    lw_x = XW'(cfg.line_width);
    fh_x = XW'(cfg.frame_height);
    if (lw_x == '0) begin
      w = XW'(1);
    end else if (lw_x > XW'(MAX_WIDTH)) begin
      w = XW'(MAX_WIDTH);
    end else begin
      w = lw_x;
    end
    if (fh_x == '0) begin
      h = XW'(1);
    end else if (fh_x > XW'(MAX_HEIGHT)) begin
      h = XW'(MAX_HEIGHT);
    end else begin
      h = fh_x;
    end

    col_x          = XW'(column);
    line_last      = (col_x + XW'(1)) >= w;
    frame_last_row = (XW'(row) + XW'(1)) >= h;
    col32          = prs_pkg::ADDR_W'(column);
    half32         = prs_pkg::ADDR_W'(column >> 1);
    pitch32        = prs_pkg::ADDR_W'(cfg.dest_pitch);

    emit       = 1'b1;
    frame_flag = frame_last_row && line_last;
    case (cfg.scale_mode)
      prs_pkg::MODE_LINE_DOUBLE: begin
        last_k   = 2'd0;
        two_rows = 1'b1;
        offset   = col32;
      end
      prs_pkg::MODE_DOUBLE: begin
        last_k   = 2'd1;
        two_rows = 1'b1;
        offset   = col32 << 1;
      end
      prs_pkg::MODE_TRIPLE: begin
        last_k   = 2'd2;
        two_rows = 1'b1;
        offset   = col32 + (col32 << 1);
      end
      prs_pkg::MODE_ONE_HALF: begin
        last_k     = 2'd2;
        two_rows   = 1'b1;
        offset     = half32 + (half32 << 1);
        // Odd columns, and a trailing even column of an odd width, are dropped.
        emit       = !column[0] && !line_last;
        frame_flag = frame_last_row && ((col_x + XW'(3)) >= w);
      end
      default: begin
        last_k   = 2'd0;
        two_rows = 1'b0;
        offset   = col32;
      end
    endcase

    a0       = row_start + offset;
    row_step = two_rows ? (pitch32 << 1) : pitch32;

    job.pixel     = pixel;
    job.addr0     = a0;
    job.addr1     = a0 + pitch32;
    job.last_k    = last_k;
    job.two_rows  = two_rows;
    job.frame_end = frame_flag;
    job_load      = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      row       <= '0;
      row_start <= prs_pkg::RESET_DEST_BASE;
    end else if (accept) begin
      if (line_last) begin
        column <= '0;
        if (frame_last_row) begin
          row       <= '0;
          row_start <= cfg.dest_base;
        end else begin
          row       <= row + RW'(1);
          row_start <= row_start + row_step;
        end
      end else begin
        column <= column + CW'(1);
      end
    end else if (base_wr && (column == '0) && (row == '0)) begin
      row_start <= base_value;
    end
  end

endmodule

`default_nettype wire

### hdl/prs_expand.sv
`default_nettype none

module prs_expand (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire prs_pkg::job_t               job,
  input  wire logic                        job_load,
  output logic                             in_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [prs_pkg::ADDR_W-1:0]  write_address,
  output logic      [prs_pkg::PIX_W-1:0]   pixel_out,
  output logic                             last_copy,
  output logic                             frame_end
);

  prs_pkg::job_t job_q;
  logic          busy;
  logic [1:0]    k;
  logic          r;
  logic          adv, cur_last;

  assign adv      = !out_valid || out_ready;
  assign cur_last = (k == job_q.last_k) && (r == job_q.two_rows);
  // A new pixel may enter in the cycle its predecessor's final write leaves.
  assign in_ready = !busy || (adv && cur_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      k         <= 2'd0;
      r         <= 1'b0;
    end else begin
      if (adv) begin
        out_valid <= busy;
        if (busy) begin
          if (cur_last) begin
            k <= 2'd0;
            r <= 1'b0;
          end else if (k == job_q.last_k) begin
            k <= 2'd0;
            r <= 1'b1;
          end else begin
            k <= k + 2'd1;
          end
        end
      end
      if (job_load) begin
        busy <= 1'b1;
      end else if (adv && cur_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) begin
      job_q <= job;
    end
    if (adv && busy) begin
      write_address <= (r ? job_q.addr1 : job_q.addr0) + prs_pkg::ADDR_W'(k);
      pixel_out     <= job_q.pixel;
      last_copy     <= cur_last;
      frame_end     <= cur_last && job_q.frame_end;
    end
  end

endmodule

`default_nettype wire
